>>> rtl/core/stb_pkg.sv
// Package for the scrolling text buffer: grid size, cell and command types,
// opcode codes and the row-ring address helpers.
// No dependencies.
package stb_pkg;

   localparam int COLS = 64;
   localparam int ROWS = 32;

   localparam int COL_W    = $clog2(COLS + 1);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int ADDR_W   = $clog2(ROWS * COLS);
   localparam int DEPTH    = ROWS * COLS;
   localparam int RD_COL_W = 7;
   localparam int RD_ROW_W = 6;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic       OPC_DRAW     = 1'b0;
   localparam logic       OPC_READ     = 1'b1;

   typedef struct packed {
      logic [7:0]  glyph;
      logic [15:0] fg;
      logic [15:0] bg;
   } cell_type;

   typedef struct packed {
      logic              is_read;
      logic              hit;
      logic              oor;
      logic [ADDR_W-1:0] addr;
      cell_type          data;
   } cmd_type;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= (ROW_W + 1)'(ROWS)) begin
         sum = sum - (ROW_W + 1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return (ADDR_W'(prow) * ADDR_W'(COLS)) + ADDR_W'(col);
   endfunction

endpackage

>>> rtl/core/stb_front.sv
// Front end of the scrolling text buffer: takes requests, keeps the cursor,
// the top-row pointer and per-row fill counts, and issues memory commands.
// Depends on stb_pkg.
module stb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [7:0]             req_glyph,
   input  logic [15:0]            req_fg_color,
   input  logic [15:0]            req_bg_color,
   input  logic [6:0]             req_read_col,
   input  logic [5:0]             req_read_row,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wrap_enable,
   input  logic                   q_full,
   output logic                   q_push,
   output stb_pkg::cmd_type       q_cmd
);

   logic                         wrap_ff;
   logic [stb_pkg::COL_W-1:0]    col_ff, col_in;
   logic [stb_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [stb_pkg::ROW_W-1:0]    top_ff, top_in;
   logic [stb_pkg::COL_W-1:0]    fill_ff [stb_pkg::ROWS];

   logic                         fire, is_draw, is_nl, do_nl, at_bottom, scroll, do_write;
   logic [stb_pkg::COL_W-1:0]    col_eff;
   logic [stb_pkg::ROW_W-1:0]    wr_phys, rd_phys;
   logic                         in_range, hit;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign fire      = req_valid && req_ready;

   always_comb begin
      is_draw   = (req_opcode == stb_pkg::OPC_DRAW);
      is_nl     = (req_glyph == stb_pkg::NEWLINE_CODE);
      do_nl     = is_nl || (wrap_ff && (col_ff >= stb_pkg::COL_W'(stb_pkg::COLS)));
      at_bottom = (row_ff == stb_pkg::ROW_W'(stb_pkg::ROWS - 1));
      scroll    = do_nl && at_bottom;
      row_in    = (do_nl && !at_bottom) ? row_ff + 1'b1 : row_ff;
      top_in    = top_ff;
      if (scroll) begin
         top_in = (top_ff == stb_pkg::ROW_W'(stb_pkg::ROWS - 1)) ? '0 : top_ff + 1'b1;
      end
      col_eff  = do_nl ? '0 : col_ff;
      do_write = !is_nl && (col_eff < stb_pkg::COL_W'(stb_pkg::COLS));
      col_in   = do_write ? col_eff + 1'b1 : col_eff;
      wr_phys  = stb_pkg::phys_row(row_in, top_in);

      in_range = (req_read_col < 7'(stb_pkg::COLS)) && (req_read_row < 6'(stb_pkg::ROWS));
      rd_phys  = stb_pkg::phys_row(req_read_row[stb_pkg::ROW_W-1:0], top_ff);
      hit      = in_range && (req_read_col[stb_pkg::COL_W-1:0] < fill_ff[rd_phys]);
   end

   always_comb begin
      q_push = fire && (is_draw ? do_write : 1'b1);
      q_cmd.is_read    = !is_draw;
      q_cmd.hit        = hit;
      q_cmd.oor        = !in_range;
      q_cmd.data.glyph = req_glyph;
      q_cmd.data.fg    = req_fg_color;
      q_cmd.data.bg    = req_bg_color;
      if (is_draw) begin
         q_cmd.addr = stb_pkg::cell_addr(wr_phys, col_eff);
      end else begin
         q_cmd.addr = stb_pkg::cell_addr(rd_phys, req_read_col[stb_pkg::COL_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b0;
         col_ff  <= '0;
         row_ff  <= '0;
         top_ff  <= '0;
         for (int i = 0; i < stb_pkg::ROWS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            wrap_ff <= csr_wrap_enable;
         end
         if (fire && is_draw) begin
            col_ff <= col_in;
            row_ff <= row_in;
            top_ff <= top_in;
            // The cleared row is the new bottom row, so a write there sets its count.
            if (do_write) begin
               fill_ff[wr_phys] <= col_in;
            end else if (scroll) begin
               fill_ff[top_ff] <= '0;
            end
         end
      end
   end

endmodule

>>> rtl/core/stb_queue.sv
// Two-entry command queue between the front and back of the text buffer.
// Depends on stb_pkg.
module stb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stb_pkg::cmd_type  push_cmd,
   output logic              full,
   output logic              pop_valid,
   output stb_pkg::cmd_type  pop_cmd,
   input  logic              pop
);

   stb_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/stb_back.sv
// Back end of the text buffer: the cell memory, its registered read and the
// response output register.
// Depends on stb_pkg.
module stb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  stb_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_cell_glyph,
   output logic [15:0]       rsp_cell_fg,
   output logic [15:0]       rsp_cell_bg,
   output logic              rsp_out_of_range
);

   stb_pkg::cell_type mem [stb_pkg::DEPTH];
   stb_pkg::cell_type mem_q_ff;
   stb_pkg::cell_type rsp_cell_ff;

   logic s1_valid_ff, s1_valid_in;
   logic s1_hit_ff, s1_oor_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_oor_ff;
   logic out_free, s1_adv, rd_issue;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      s1_adv       = s1_valid_ff && out_free;
      cmd_pop      = cmd_valid && (!cmd.is_read || !s1_valid_ff || out_free);
      rd_issue     = cmd_pop && cmd.is_read;
      s1_valid_in  = rd_issue || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && !cmd.is_read) begin
         mem[cmd.addr] <= cmd.data;
      end
      if (rd_issue) begin
         mem_q_ff  <= mem[cmd.addr];
         s1_hit_ff <= cmd.hit;
         s1_oor_ff <= cmd.oor;
      end
      if (s1_adv) begin
         rsp_cell_ff <= s1_hit_ff ? mem_q_ff : '0;
         rsp_oor_ff  <= s1_oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_glyph   = rsp_cell_ff.glyph;
   assign rsp_cell_fg      = rsp_cell_ff.fg;
   assign rsp_cell_bg      = rsp_cell_ff.bg;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

>>> rtl/core/scrolling_text_buffer.sv
// Scrolling terminal text buffer, top level: front end, command queue, back end.
// Depends on stb_pkg, stb_front, stb_queue and stb_back.
//
// A ROWS by COLS grid of glyph cells with a write cursor. Draw requests write a
// glyph at the cursor or, for a newline, move or scroll; read requests return one
// cell. The block sustains one request per clock while read responses are not
// held off; a read response passes the queue entry, the registered cell memory
// read and the output register. Scrolling moves a top-row pointer and per-row fill
// counts mark cleared cells, so reset and scrolls need no clearing pass and the
// block takes requests from the first cycle after reset. The wrap_enable
// register is written through the csr port, which is always ready.
module scrolling_text_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_glyph,
   input  logic [15:0] req_fg_color,
   input  logic [15:0] req_bg_color,
   input  logic [6:0]  req_read_col,
   input  logic [5:0]  req_read_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_cell_glyph,
   output logic [15:0] rsp_cell_fg,
   output logic [15:0] rsp_cell_bg,
   output logic        rsp_out_of_range,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wrap_enable
);

   logic             q_full, q_push, q_valid, q_pop;
   stb_pkg::cmd_type push_cmd, pop_cmd;

   stb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_glyph       (req_glyph),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wrap_enable (csr_wrap_enable),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   stb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd),
      .pop       (q_pop)
   );

   stb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_valid),
      .cmd              (pop_cmd),
      .cmd_pop          (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_glyph   (rsp_cell_glyph),
      .rsp_cell_fg      (rsp_cell_fg),
      .rsp_cell_bg      (rsp_cell_bg),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

>>> rtl/core/stb_checker.sv
// Port-level checks for the scrolling text buffer, bound to its top level.
// Depends on scrolling_text_buffer.
module stb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_cell_glyph,
   input logic [15:0] rsp_cell_fg,
   input logic [15:0] rsp_cell_bg,
   input logic        rsp_out_of_range
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_glyph) &&
         $stable(rsp_cell_fg) && $stable(rsp_cell_bg) && $stable(rsp_out_of_range))
      else $error("response changed while stalled");

   // An out-of-range read carries all-zero cell data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_cell_glyph == 8'd0 && rsp_cell_fg == 16'd0 && rsp_cell_bg == 16'd0)
      else $error("out-of-range response with nonzero data");

   // No response is pending right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind scrolling_text_buffer stb_checker u_stb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_cell_glyph   (rsp_cell_glyph),
   .rsp_cell_fg      (rsp_cell_fg),
   .rsp_cell_bg      (rsp_cell_bg),
   .rsp_out_of_range (rsp_out_of_range)
);

>>> sim/tb_scrolling_text_buffer.sv
`timescale 1ns / 1ps
// Self-checking testbench for scrolling_text_buffer: directed and random requests
// checked against a behavioral model of the glyph grid. Depends on stb_pkg.
module tb_scrolling_text_buffer;

   localparam int         COLS         = stb_pkg::COLS;
   localparam int         ROWS         = stb_pkg::ROWS;
   localparam logic [7:0] NEWLINE_CODE = stb_pkg::NEWLINE_CODE;
   localparam logic       OPC_DRAW     = stb_pkg::OPC_DRAW;
   localparam logic       OPC_READ     = stb_pkg::OPC_READ;

   typedef stb_pkg::cell_type cell_type;

   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 80;
   localparam int PHASE_ITEMS  = 110;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  glyph;
      logic [15:0] fg;
      logic [15:0] bg;
      logic [6:0]  col;
      logic [5:0]  row;
   } request_type;

   typedef struct packed {
      cell_type data;
      logic     oor;
   } cell_reply;

   typedef struct packed {
      logic        set_wrap;
      logic        wrap_value;
      request_type req;
      logic        fixed;
      cell_reply   reply;
   } script_row;

   localparam cell_reply BLANK_CELL = '0;
   localparam cell_reply OFF_GRID   = '{data: '0, oor: 1'b1};
   localparam cell_reply FULL_CELL  = '{data: '{8'hFF, 16'hFFFF, 16'hFFFF}, oor: 1'b0};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [7:0]  req_glyph;
   logic [15:0] req_fg_color;
   logic [15:0] req_bg_color;
   logic [6:0]  req_read_col;
   logic [5:0]  req_read_row;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_cell_glyph;
   logic [15:0] rsp_cell_fg;
   logic [15:0] rsp_cell_bg;
   logic        rsp_out_of_range;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_wrap_enable;

   cell_type    screen [ROWS][COLS];
   int unsigned cursor_x;
   int unsigned cursor_y;
   int unsigned top_line;
   bit          wrap_on;

   cell_reply   pending_reads [$];
   script_row   directed [24];
   int          errors;
   int          sent;
   bit          calm;
   bit          req_idle_on;
   bit          rsp_idle_on;
   bit          hold_rsp;

   scrolling_text_buffer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_glyph       (req_glyph),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_glyph  (rsp_cell_glyph),
      .rsp_cell_fg     (rsp_cell_fg),
      .rsp_cell_bg     (rsp_cell_bg),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wrap_enable (csr_wrap_enable)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_screen();
      for (int y = 0; y < ROWS; y++) begin
         for (int x = 0; x < COLS; x++) begin
            screen[y][x] = '0;
         end
      end
      cursor_x = 0;
      cursor_y = 0;
      top_line = 0;
      wrap_on  = 1'b0;
   endfunction

   function automatic void next_line();
      if (cursor_y >= ROWS - 1) begin
         cursor_y = ROWS - 1;
         for (int x = 0; x < COLS; x++) begin
            screen[top_line][x] = '0;
         end
         top_line = (top_line + 1) % ROWS;
      end else begin
         cursor_y++;
      end
      cursor_x = 0;
   endfunction

   function automatic bit predict_cell(input request_type r, output cell_reply reply);
      int unsigned line;
      reply = '0;
      if (r.opcode == OPC_READ) begin
         if (r.col >= COLS || r.row >= ROWS) begin
            reply.oor = 1'b1;
         end else begin
            line = (r.row + top_line) % ROWS;
            reply.data = screen[line][r.col];
         end
         return 1'b1;
      end
      if (r.glyph == NEWLINE_CODE) begin
         next_line();
         return 1'b0;
      end
      if (wrap_on && cursor_x >= COLS) begin
         next_line();
      end
      if (cursor_x >= COLS) begin
         cursor_x = COLS;
         return 1'b0;
      end
      line = (cursor_y + top_line) % ROWS;
      screen[line][cursor_x] = {r.glyph, r.fg, r.bg};
      cursor_x++;
      return 1'b0;
   endfunction

   function automatic request_type random_request();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[$bits(request_type)-1:0];
   endfunction

   function automatic request_type make_draw(input bit newline);
      request_type r;
      r = random_request();
      r.opcode = OPC_DRAW;
      if (newline) begin
         r.glyph = NEWLINE_CODE;
      end
      return r;
   endfunction

   function automatic request_type cell_read();
      request_type r;
      int          pick;
      r = random_request();
      r.opcode = OPC_READ;
      pick = $urandom_range(0, 9);
      if (pick != 0) begin
         if (pick < 5) begin
            r.row = 6'(cursor_y);
         end else if (pick < 7) begin
            r.row = 6'((cursor_y + ROWS - 1) % ROWS);
         end else begin
            r.row = 6'($urandom_range(0, ROWS - 1));
         end
         if (pick == 4) begin
            r.col = 7'((cursor_x > 0) ? cursor_x - 1 : 0);
         end else begin
            r.col = 7'($urandom_range(0, COLS - 1));
         end
      end
      return r;
   endfunction

   task automatic issue(input request_type r, input bit fixed, input cell_reply fixed_reply);
      cell_reply reply;
      int        gap;
      @(negedge clock);
      if (!calm && req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
      req_opcode   = r.opcode;
      req_glyph    = r.glyph;
      req_fg_color = r.fg;
      req_bg_color = r.bg;
      req_read_col = r.col;
      req_read_row = r.row;
      req_valid    = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (predict_cell(r, reply)) begin
         pending_reads.push_back(fixed ? fixed_reply : reply);
      end
      sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_wrap(input bit value);
      settle();
      @(negedge clock);
      csr_valid       = 1'b1;
      csr_wrap_enable = value;
      do @(posedge clock); while (!csr_ready);
      wrap_on = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_sequence();
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      req_idle_on = ($urandom_range(0, 3) != 0);
      case (kind)
         0, 1, 2: begin
            len = $urandom_range(1, 20);
            repeat (len) begin
               issue(make_draw(1'b0), 1'b0, '0);
               if ($urandom_range(0, 3) == 0) begin
                  issue(cell_read(), 1'b0, '0);
               end
            end
            if ($urandom_range(0, 1) == 1) begin
               issue(make_draw(1'b1), 1'b0, '0);
            end
         end
         3, 9: begin
            len = $urandom_range(60, 75);
            repeat (len) begin
               issue(make_draw(1'b0), 1'b0, '0);
               if ($urandom_range(0, 7) == 0) begin
                  issue(cell_read(), 1'b0, '0);
               end
            end
            repeat (3) issue(cell_read(), 1'b0, '0);
         end
         4, 5: begin
            len = $urandom_range(1, 12);
            repeat (len) issue(make_draw(1'b1), 1'b0, '0);
         end
         6, 7: begin
            len = $urandom_range(1, 8);
            repeat (len) issue(cell_read(), 1'b0, '0);
         end
         default: begin
            len = $urandom_range(1, 6);
            repeat (len) issue(random_request(), 1'b0, '0);
         end
      endcase
   endtask

   always @(posedge clock) begin : rsp_check
      cell_reply want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reads.size() == 0) begin
            $error("cell response arrived with no read request outstanding");
            errors++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_cell_glyph !== want.data.glyph) begin
               $error("cell_glyph: expected %0h, got %0h", want.data.glyph, rsp_cell_glyph);
               errors++;
            end
            if (rsp_cell_fg !== want.data.fg) begin
               $error("cell_fg: expected %0h, got %0h", want.data.fg, rsp_cell_fg);
               errors++;
            end
            if (rsp_cell_bg !== want.data.bg) begin
               $error("cell_bg: expected %0h, got %0h", want.data.bg, rsp_cell_bg);
               errors++;
            end
            if (rsp_out_of_range !== want.oor) begin
               $error("out_of_range: expected %0b, got %0b", want.oor, rsp_out_of_range);
               errors++;
            end
         end
      end
   end

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp  = 1'b0;
            rsp_ready = 1'b1;
         end else if (!calm && rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            stall = $urandom_range(1, 12);
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
         if ($urandom_range(0, 63) == 0) begin
            rsp_idle_on = !rsp_idle_on;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OPC_DRAW;
      req_glyph       = '0;
      req_fg_color    = '0;
      req_bg_color    = '0;
      req_read_col    = '0;
      req_read_row    = '0;
      csr_valid       = 1'b0;
      csr_wrap_enable = 1'b0;
      errors          = 0;
      sent            = 0;
      calm            = 1'b0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      hold_rsp        = 1'b0;
      clear_screen();

      directed = '{
         '{1'b1, 1'b0, '0, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'hAA, 16'h1234, 16'hABCD, 7'd0, 6'd0}, 1'b1, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd127, 6'd63}, 1'b1, OFF_GRID},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd64, 6'd0}, 1'b1, OFF_GRID},
         '{1'b0, 1'b0, '{OPC_READ, 8'h55, 16'h5555, 16'hAAAA, 7'd63, 6'd32}, 1'b1, OFF_GRID},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd63, 6'd31}, 1'b1, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_DRAW, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd127, 6'd63}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_DRAW, 8'h00, 16'h0000, 16'h0000, 7'd0, 6'd0}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_DRAW, 8'h41, 16'hF800, 16'h001F, 7'd5, 6'd5}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd0, 6'd0}, 1'b1, FULL_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd1, 6'd0}, 1'b1, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd2, 6'd0}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_DRAW, NEWLINE_CODE, 16'hFFFF, 16'hFFFF, 7'd0, 6'd0}, 1'b0,
           BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd0, 6'd1}, 1'b1, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_DRAW, 8'h7E, 16'h07E0, 16'hFFFF, 7'd0, 6'd0}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd0, 6'd1}, 1'b0, BLANK_CELL},
         '{1'b1, 1'b1, '0, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd1, 6'd1}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_DRAW, 8'h80, 16'h0001, 16'h8000, 7'd64, 6'd32}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd1, 6'd1}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd64, 6'd32}, 1'b1, OFF_GRID},
         '{1'b0, 1'b0, '{OPC_DRAW, NEWLINE_CODE, 16'h0000, 16'h0000, 7'd0, 6'd0}, 1'b0,
           BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd1, 6'd1}, 1'b0, BLANK_CELL},
         '{1'b0, 1'b0, '{OPC_READ, 8'h00, 16'h0000, 16'h0000, 7'd0, 6'd2}, 1'b0, BLANK_CELL}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].set_wrap) begin
            set_wrap(directed[i].wrap_value);
         end else begin
            issue(directed[i].req, directed[i].fixed, directed[i].reply);
         end
      end

      // The input stalls here while the response side holds off.
      for (int phase = 0; phase < 4; phase++) begin
         set_wrap(phase % 2 == 0);
         calm = (phase == 3);
         if (phase == 1) begin
            req_idle_on = 1'b0;
            hold_rsp    = 1'b1;
            repeat (40) issue(cell_read(), 1'b0, '0);
         end
         while (sent < (phase + 1) * PHASE_ITEMS + 20) begin
            run_sequence();
         end
      end

      settle();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
